/* rtl/ble_pkg.sv */
// Shared types and constants for the bounded ordered list engine.
// No dependencies.
package ble_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [3:0] {
        F_INS_FRONT = 4'd0,
        F_INS_BACK  = 4'd1,
        F_INS_AFTER = 4'd2,
        F_DEL_FRONT = 4'd3,
        F_DEL_VALUE = 4'd4,
        F_DEL_BACK  = 4'd5,
        F_SEARCH    = 4'd6,
        F_COUNT     = 4'd7,
        F_SUM       = 4'd8
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_func                    func;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] key;
    } t_item;

    typedef struct packed {
        t_status                  status;
        logic                     found;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [DATA_W-1:0] total;
    } t_result;

endpackage

/* rtl/bounded_ordered_list_engine.sv */
// Ordered list of up to CAPACITY values in a circular buffer (head pointer + length).
// Front/back inserts and deletes, count, undefined functions and empty/full cases: strobe in the cycle after start.
// Search and sum scan the entries; delete by value and insert after may also shift entries.
// One RAM read port and one write port move one entry a cycle.
// One item at a time; busy drops in the strobe cycle; results cannot be held off.
// Sync reset empties the list; entry storage is not cleared.
module bounded_ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ble_pkg::t_item   i_item,
    output logic             o_valid,
    output ble_pkg::t_result o_result
);
    import ble_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_P = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_len, n_len;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_pidx, n_pidx;
    logic [CW-1:0]      r_h, n_h;
    logic               r_pv, n_pv;
    t_func              r_op, n_op;
    logic [DATA_W-1:0]  r_key, n_key;
    logic [DATA_W-1:0]  r_value, n_value;
    logic               r_valid, n_valid;
    t_result            r_res, n_res;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [DATA_W-1:0]  wdata;
    logic [AW-1:0]      raddr;
    logic [DATA_W-1:0]  rdata;
    logic               walk_clr;
    logic               walk_en;
    logic               match;
    logic [DATA_W-1:0]  acc;
    logic [AW-1:0]      head_m1;
    logic [AW-1:0]      head_p1;
    logic               full;
    logic               empty;
    logic [CW-1:0]      scan_idx;

    function automatic logic [AW-1:0] f_phys(logic [AW-1:0] head, logic [CW-1:0] idx);
        logic [AW:0] s;
        s = {1'b0, head} + (AW + 1)'(idx);
        if (s >= CAP_P) begin
            s = s - CAP_P;
        end
        return s[AW-1:0];
    endfunction

    ble_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ble_walk u_walk (
        .i_clk   (i_clk),
        .i_clr   (walk_clr),
        .i_en    (walk_en),
        .i_data  (rdata),
        .i_key   (r_key),
        .o_match (match),
        .o_acc   (acc)
    );

    assign head_m1  = (r_head == '0) ? LAST : r_head - 1'b1;
    assign head_p1  = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign full     = (r_len == CAP_C);
    assign empty    = (r_len == '0);
    assign walk_en  = r_pv && (r_state == S_SCAN);
    assign scan_idx = (r_op != F_DEL_VALUE) ? r_k :
                      (CW'(r_k + 1'b1) == r_len) ? '0 : CW'(r_k + 1'b1);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_len     = r_len;
        n_k       = r_k;
        n_pidx    = r_pidx;
        n_h       = r_h;
        n_pv      = r_pv;
        n_op      = r_op;
        n_key     = r_key;
        n_value   = r_value;
        n_valid   = 1'b0;
        n_res     = r_res;
        n_res.status = ST_OK;
        n_res.found  = 1'b0;
        n_res.total  = '0;
        we        = 1'b0;
        waddr     = '0;
        wdata     = r_value;
        raddr     = '0;
        walk_clr  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_item.func;
                    n_key    = i_item.key;
                    n_value  = i_item.value;
                    n_k      = '0;
                    n_pv     = 1'b0;
                    walk_clr = 1'b1;
                    n_valid  = 1'b1;
                    unique case (i_item.func) inside
                        F_INS_FRONT: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                we     = 1'b1;
                                waddr  = head_m1;
                                wdata  = i_item.value;
                                n_head = head_m1;
                                n_len  = r_len + 1'b1;
                            end
                        end
                        F_INS_BACK: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                we    = 1'b1;
                                waddr = f_phys(r_head, r_len);
                                wdata = i_item.value;
                                n_len = r_len + 1'b1;
                            end
                        end
                        F_INS_AFTER: begin
                            if (empty) begin
                                we     = 1'b1;
                                waddr  = head_m1;
                                wdata  = i_item.value;
                                n_head = head_m1;
                                n_len  = r_len + 1'b1;
                            end else if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_valid = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        F_DEL_FRONT: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_head = head_p1;
                                n_len  = r_len - 1'b1;
                            end
                        end
                        F_DEL_BACK: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_len = r_len - 1'b1;
                            end
                        end
                        F_DEL_VALUE, F_SEARCH, F_SUM: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        F_COUNT: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end
                        end
                        default: begin
                            n_res.status = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_k < r_len) begin
                    raddr  = f_phys(r_head, scan_idx);
                    n_k    = r_k + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = scan_idx;
                end else begin
                    n_pv = 1'b0;
                end
                if (match && (r_op != F_SUM)) begin
                    n_pv = 1'b0;
                    unique case (r_op)
                        F_INS_AFTER: begin
                            n_h     = r_pidx;
                            n_k     = r_len - 1'b1;
                            n_state = S_SHIFT;
                        end
                        F_DEL_VALUE: begin
                            if (r_pidx == '0) begin
                                n_head  = head_p1;
                                n_len   = r_len - 1'b1;
                                n_valid = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_h     = r_pidx;
                                n_k     = r_pidx + 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_res.found = 1'b1;
                            n_valid     = 1'b1;
                            n_state     = S_IDLE;
                        end
                    endcase
                end else if (!r_pv && (r_k >= r_len)) begin
                    if (r_op == F_SUM) begin
                        n_res.total = acc;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_SHIFT: begin
                if (r_op == F_INS_AFTER) begin
                    if (r_k > r_h) begin
                        raddr  = f_phys(r_head, r_k);
                        n_k    = r_k - 1'b1;
                        n_pv   = 1'b1;
                        n_pidx = r_k;
                    end else begin
                        n_pv = 1'b0;
                    end
                    if (r_pv) begin
                        we    = 1'b1;
                        waddr = f_phys(r_head, CW'(r_pidx + 1'b1));
                        wdata = rdata;
                    end else if (r_k <= r_h) begin
                        we      = 1'b1;
                        waddr   = f_phys(r_head, CW'(r_h + 1'b1));
                        wdata   = r_value;
                        n_len   = r_len + 1'b1;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_k < r_len) begin
                        raddr  = f_phys(r_head, r_k);
                        n_k    = r_k + 1'b1;
                        n_pv   = 1'b1;
                        n_pidx = r_k;
                    end else begin
                        n_pv = 1'b0;
                    end
                    if (r_pv) begin
                        we    = 1'b1;
                        waddr = f_phys(r_head, CW'(r_pidx - 1'b1));
                        wdata = rdata;
                    end else if (r_k >= r_len) begin
                        n_len   = r_len - 1'b1;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.entry_count = COUNT_W'(n_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_len   <= '0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_len   <= n_len;
            r_pv    <= n_pv;
            r_valid <= n_valid;
        end
        r_k     <= n_k;
        r_pidx  <= n_pidx;
        r_h     <= n_h;
        r_op    <= n_op;
        r_key   <= n_key;
        r_value <= n_value;
        r_res   <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

/* rtl/ble_ram.sv */
// Entry storage: one write port, one read port, registered read data.
// Depends on ble_pkg.
module ble_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ble_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [ble_pkg::DATA_W-1:0] o_rdata
);
    import ble_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ble_walk.sv */
// Shared walk unit: key compare and wrapping accumulate on each read beat.
// Depends on ble_pkg.
module ble_walk (
    input  logic                       i_clk,
    input  logic                       i_clr,
    input  logic                       i_en,
    input  logic [ble_pkg::DATA_W-1:0] i_data,
    input  logic [ble_pkg::DATA_W-1:0] i_key,
    output logic                       o_match,
    output logic [ble_pkg::DATA_W-1:0] o_acc
);
    import ble_pkg::*;

    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_clr) begin
            n_acc = '0;
        end else if (i_en) begin
            n_acc = r_acc + i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_match = i_en && (i_data == i_key);
    assign o_acc   = r_acc;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for bounded_ordered_list_engine: a queue-fed command driver, a result
// monitor and a behavioral list predictor. Depends on ble_pkg and the engine RTL.
module testbench;
    import ble_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int FUNC_MAX    = (1 << $bits(t_func)) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 4 * CAPACITY;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } t_mix;

    typedef struct {
        t_item       item;
        int unsigned idle_pct;
    } t_queued_op;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    t_queued_op  queued_ops[$];
    t_queued_op  next_op;
    t_result     list_outcomes[$];
    t_result     want;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;

    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    int                       list_len = 0;

    bounded_ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_status insert_at(input int pos, input logic signed [DATA_W-1:0] v);
        if (list_len >= CAPACITY) return ST_FULL;
        for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
        list_vals[pos] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic void remove_at(input int pos);
        for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
        list_len--;
    endfunction

    function automatic t_result apply_list_op(input t_item op);
        t_result r;
        int      pos;
        r = '0;
        r.status = ST_OK;
        case (op.func)
            F_INS_FRONT: r.status = insert_at(0, op.value);
            F_INS_BACK:  r.status = insert_at(list_len, op.value);
            F_INS_AFTER: begin
                if (list_len == 0) begin
                    r.status = insert_at(0, op.value);
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    r.status = ST_NOT_FOUND;
                    for (int i = 0; i < list_len; i++) begin
                        if (list_vals[i] == op.key) begin
                            void'(insert_at(i + 1, op.value));
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            F_DEL_FRONT: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else remove_at(0);
            end
            F_DEL_VALUE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // second entry through tail first, head last
                    pos = -1;
                    for (int i = 1; i < list_len; i++) begin
                        if (list_vals[i] == op.key) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos < 0 && list_vals[0] == op.key) pos = 0;
                    if (pos < 0) r.status = ST_NOT_FOUND;
                    else remove_at(pos);
                end
            end
            F_DEL_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            F_SEARCH: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        if (list_vals[i] == op.key) begin
                            r.found = 1'b1;
                            break;
                        end
                    end
                    r.status = r.found ? ST_OK : ST_NOT_FOUND;
                end
            end
            F_COUNT: begin
                if (list_len == 0) r.status = ST_EMPTY;
            end
            F_SUM: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else for (int i = 0; i < list_len; i++) r.total = r.total + list_vals[i];
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(list_len);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2, 3:    return $urandom;
            default: return $urandom_range(0, 11) - 6;
        endcase
    endfunction

    function automatic t_item make_op(input t_mix mix);
        t_item       op;
        int unsigned pick;
        op.value = rand_word();
        op.key   = rand_word();
        pick     = $urandom_range(0, 99);
        if (mix == MIX_GROW && pick < 85)
            op.func = t_func'($urandom_range(int'(F_INS_FRONT), int'(F_INS_AFTER)));
        else if (mix == MIX_SHRINK && pick < 85)
            op.func = t_func'($urandom_range(int'(F_DEL_FRONT), int'(F_DEL_BACK)));
        else if (pick < 92)
            op.func = t_func'($urandom_range(int'(F_INS_FRONT), int'(F_SUM)));
        else
            op.func = t_func'($urandom_range(int'(F_SUM) + 1, FUNC_MAX));
        return op;
    endfunction

    function automatic void queue_op(input t_func f, input logic signed [DATA_W-1:0] v,
                                     input logic signed [DATA_W-1:0] k, input int unsigned pct);
        t_queued_op q;
        q.item.func  = f;
        q.item.value = v;
        q.item.key   = k;
        q.idle_pct   = pct;
        queued_ops.push_back(q);
    endfunction

    // driver: start held until the beat is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) list_outcomes.push_back(apply_list_op(i_item));
            if (start && busy) begin
            end else if (queued_ops.size() != 0 &&
                         $urandom_range(0, 99) >= queued_ops[0].idle_pct) begin
                next_op = queued_ops.pop_front();
                start  <= 1'b1;
                i_item <= next_op.item;
            end else begin
                start        <= 1'b0;
                i_item.value <= $urandom;
                i_item.key   <= $urandom;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (list_outcomes.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end else begin
                want = list_outcomes.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    mismatches++;
                end
                if (o_result.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_result.found);
                    mismatches++;
                end
                if (o_result.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_result.entry_count);
                    mismatches++;
                end
                if (o_result.total !== want.total) begin
                    $error("total: expected %0d, got %0d", want.total, o_result.total);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("bounded_ordered_list_engine: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic signed [DATA_W-1:0] max_w;
        logic signed [DATA_W-1:0] min_w;
        int unsigned              phase_pct[4];
        t_item                    gen_item;
        max_w = {1'b0, {(DATA_W-1){1'b1}}};
        min_w = {1'b1, {(DATA_W-1){1'b0}}};
        phase_pct = '{0, 67, 0, 32};

        // empty-list cases, then head/tail handling and wrapping sum
        queue_op(F_COUNT, 0, 0, 0);
        queue_op(F_SUM, 0, 0, 0);
        queue_op(F_SEARCH, 0, 0, 0);
        queue_op(F_DEL_FRONT, 0, 0, 0);
        queue_op(F_DEL_BACK, 0, 0, 0);
        queue_op(F_DEL_VALUE, 0, 0, 0);
        queue_op(F_INS_AFTER, 9, 1, 0);
        queue_op(F_DEL_VALUE, 0, 9, 0);
        queue_op(F_INS_BACK, max_w, 0, 0);
        queue_op(F_INS_FRONT, min_w, 0, 0);
        queue_op(F_INS_AFTER, max_w, max_w, 0);
        queue_op(F_SUM, 0, 0, 0);
        queue_op(F_INS_AFTER, 3, 5, 0);
        queue_op(F_SEARCH, 0, min_w, 0);
        queue_op(F_SEARCH, 0, 0, 0);
        queue_op(F_INS_BACK, min_w, 0, 0);
        queue_op(F_DEL_VALUE, 0, min_w, 0);
        queue_op(F_DEL_VALUE, 0, min_w, 0);
        queue_op(F_DEL_FRONT, 0, 0, 0);
        queue_op(F_DEL_BACK, 0, 0, 0);
        queue_op(t_func'(FUNC_MAX), -1, -1, 0);
        queue_op(t_func'($urandom_range(int'(F_SUM) + 1, FUNC_MAX)), 0, 0, 0);
        queue_op(F_INS_FRONT, -1, 0, 0);
        queue_op(F_COUNT, 0, 0, 0);

        // grow, churn, then shrink the list in each idle phase
        foreach (phase_pct[p]) begin
            for (int i = 0; i < 95; i++) begin
                gen_item = make_op(MIX_GROW);
                queue_op(gen_item.func, rand_word(), rand_word(), phase_pct[p]);
            end
            for (int i = 0; i < 25; i++) begin
                gen_item = make_op(MIX_ANY);
                queue_op(gen_item.func, gen_item.value, gen_item.key, phase_pct[p]);
            end
            for (int i = 0; i < 70; i++) begin
                gen_item = make_op(MIX_SHRINK);
                queue_op(gen_item.func, gen_item.value, gen_item.key, phase_pct[p]);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_ops.size() != 0 || start || list_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (list_outcomes.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("bounded_ordered_list_engine: match");
        end else begin
            $display("bounded_ordered_list_engine: mismatch");
        end
        $finish;
    end

endmodule
